// ===== src/sar_pkg.sv =====
// ---------------------------------------------------------------------------
// sar_pkg: shared constants and types of the servo angle ramp generator
// Command codes, register indexes, field widths and range limits.
// ---------------------------------------------------------------------------
`default_nettype none

package sar_pkg;

  localparam int FuncW    = 3;
  localparam int AngleW   = 8;
  localparam int RampW    = 14;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // product |target - start| * elapsed, and the rounding numerator above it
  localparam int ProdW = AngleW + RampW - 1;
  localparam int NumW  = ProdW + 1;

  localparam logic [FuncW-1:0] FuncTick   = 3'd0;
  localparam logic [FuncW-1:0] FuncJump   = 3'd1;
  localparam logic [FuncW-1:0] FuncMove   = 3'd2;
  localparam logic [FuncW-1:0] FuncPause  = 3'd3;
  localparam logic [FuncW-1:0] FuncResume = 3'd4;

  localparam logic [CfgIdxW-1:0] RegRampMs     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRestAngle  = 2'd1;

  localparam logic [AngleW-1:0] AngleMax   = 8'd180;
  localparam logic [AngleW-1:0] RestAngle  = 8'd90;
  localparam logic [RampW-1:0]  RampMin    = 14'd200;
  localparam logic [RampW-1:0]  RampMax    = 14'd10000;
  localparam logic [RampW-1:0]  RampReset  = 14'd1000;

  localparam logic [3:0] MulLast = 4'(RampW - 1);
  localparam logic [3:0] DivLast = 4'(AngleW - 1);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StDiv  = 4'b0100,
    StDone = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== src/sar_ifs.sv =====
// ---------------------------------------------------------------------------
// sar_ifs: channel interfaces of the servo angle ramp generator
// Command words, result words and register writes, each valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface sar_cmd_if import sar_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [AngleW-1:0] angle;

  modport source (output valid, func, angle, input ready);
  modport sink   (input valid, func, angle, output ready);
endinterface

interface sar_res_if import sar_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AngleW-1:0] position;
  logic              drive_write;
  logic              in_motion;
  logic              on_hold;

  modport source (output valid, position, drive_write, in_motion, on_hold, input ready);
  modport sink   (input valid, position, drive_write, in_motion, on_hold, output ready);
endinterface

interface sar_cfg_if import sar_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/servo_angle_ramp.sv =====
// ---------------------------------------------------------------------------
// servo_angle_ramp: servo angle ramp generator
// Applies tick, jump, move, pause and resume commands and reports the angle.
//
//   channel  dir  fields                                     word
//   cmd      in   func, angle                                one command
//   res      out  position, drive_write, in_motion, on_hold  one result
//   cfg      in   index, data                                one register write
//
// A tick during a move runs through StMul, a bit-serial product of the angle
// span and elapsed ticks, then StDiv, a restoring divide by twice the ramp,
// and StDone to finish. Every other command answers in the accept cycle.
// Reset is synchronous and restores the ramp to 1000 and all angles to 90.
// A result waits in the output register; a tick finishing against a full
// output register holds until it drains.
// ---------------------------------------------------------------------------
`default_nettype none

module servo_angle_ramp import sar_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  sar_cmd_if.sink   cmd,
  sar_res_if.source res,
  sar_cfg_if.sink   cfg
);

  state_t            state;
  logic [RampW-1:0]  ramp_ms;
  logic [AngleW-1:0] current_angle;
  logic [AngleW-1:0] start_angle;
  logic [AngleW-1:0] target_angle;
  logic [RampW-1:0]  elapsed_ticks;
  logic              moving_flag;
  logic              paused_flag;

  // serial datapath
  logic [RampW-1:0]  esh;
  logic [AngleW-1:0] span;
  logic              neg;
  logic [ProdW-1:0]  acc;
  logic [NumW-1:0]   rem;
  logic [NumW-1:0]   dsh;
  logic [AngleW-1:0] quo;
  logic [3:0]        cnt;

  logic              out_valid;
  logic [AngleW-1:0] out_position;
  logic              out_drive;
  logic              out_motion;
  logic              out_hold;

  logic              slot_free;
  logic              cmd_fire;
  logic              out_load;

  // command effects, valid in the accept cycle
  logic [AngleW-1:0] req;
  logic [AngleW-1:0] current_next;
  logic [AngleW-1:0] start_next;
  logic [AngleW-1:0] target_next;
  logic [RampW-1:0]  elapsed_next;
  logic              moving_next;
  logic              paused_next;
  logic              drive_next;
  logic              calc;
  logic [RampW:0]    elapsed_inc;
  logic [RampW-1:0]  ramp_next;

  logic [ProdW-1:0]  acc_next;
  logic [NumW-1:0]   num;
  logic              fits;
  logic [AngleW-1:0] pos_next;

  assign slot_free = !out_valid || res.ready;
  assign cmd.ready = (state == StIdle) && slot_free;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  assign res.valid       = out_valid;
  assign res.position    = out_position;
  assign res.drive_write = out_drive;
  assign res.in_motion   = out_motion;
  assign res.on_hold     = out_hold;

  assign req = (cmd.angle > AngleMax) ? AngleMax : cmd.angle;
  assign elapsed_inc = {1'b0, elapsed_ticks} + {{RampW{1'b0}}, 1'b1};

  always_comb begin
    current_next = current_angle;
    start_next   = start_angle;
    target_next  = target_angle;
    elapsed_next = elapsed_ticks;
    moving_next  = moving_flag;
    paused_next  = paused_flag;
    drive_next   = 1'b0;
    calc         = 1'b0;
    unique case (cmd.func)
      FuncTick: begin
        if (moving_flag) begin
          calc = 1'b1;
          // saturate at the ramp; a shortened ramp ends the move at once
          elapsed_next = (elapsed_inc > {1'b0, ramp_ms}) ? ramp_ms
                                                         : elapsed_inc[RampW-1:0];
        end
      end
      FuncJump: begin
        current_next = req;
        start_next   = req;
        target_next  = req;
        moving_next  = 1'b0;
        paused_next  = 1'b0;
        drive_next   = 1'b1;
      end
      FuncMove: begin
        if (!(req == target_angle && !moving_flag && !paused_flag)) begin
          start_next   = current_angle;
          target_next  = req;
          elapsed_next = '0;
          moving_next  = 1'b1;
          paused_next  = 1'b0;
        end
      end
      FuncPause: begin
        if (moving_flag && !paused_flag) begin
          moving_next = 1'b0;
          paused_next = 1'b1;
        end
      end
      FuncResume: begin
        if (paused_flag) begin
          moving_next = 1'b1;
          paused_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cfg.data < CfgDataW'(RampMin)) begin
      ramp_next = RampMin;
    end else if (cfg.data > CfgDataW'(RampMax)) begin
      ramp_next = RampMax;
    end else begin
      ramp_next = cfg.data[RampW-1:0];
    end
  end

  assign out_load = ((state == StIdle) && cmd_fire && !calc) ||
                    ((state == StDone) && slot_free);

  // shift-add one multiplier bit per cycle, most significant first
  assign acc_next = {acc[ProdW-2:0], 1'b0} + (esh[RampW-1] ? ProdW'(span) : '0);
  // round half up going forward; going backward the offset drops by one
  assign num  = {acc_next, 1'b0} + NumW'(ramp_ms) - NumW'(neg);
  assign fits = rem >= dsh;
  assign pos_next = neg ? (start_angle - quo) : (start_angle + quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= StIdle;
      out_valid     <= 1'b0;
      ramp_ms       <= RampReset;
      current_angle <= RestAngle;
      start_angle   <= RestAngle;
      target_angle  <= RestAngle;
      elapsed_ticks <= '0;
      moving_flag   <= 1'b0;
      paused_flag   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      // the rest angle only matters at reset, which restores it anyway
      if (cfg.valid && cfg.index == RegRampMs) begin
        ramp_ms <= ramp_next;
      end

      unique case (state)
        StIdle: begin
          if (cmd_fire) begin
            elapsed_ticks <= elapsed_next;
            if (calc) begin
              esh   <= elapsed_next;
              neg   <= target_angle < start_angle;
              span  <= (target_angle < start_angle) ? (start_angle - target_angle)
                                                    : (target_angle - start_angle);
              acc   <= '0;
              cnt   <= MulLast;
              state <= StMul;
            end else begin
              current_angle <= current_next;
              start_angle   <= start_next;
              target_angle  <= target_next;
              moving_flag   <= moving_next;
              paused_flag   <= paused_next;
              out_position  <= current_next;
              out_drive     <= drive_next;
              out_motion    <= moving_next;
              out_hold      <= paused_next;
            end
          end
        end
        StMul: begin
          acc <= acc_next;
          esh <= {esh[RampW-2:0], 1'b0};
          if (cnt == '0) begin
            // load the divider with the rounding numerator
            rem   <= num;
            dsh   <= {ramp_ms, {AngleW{1'b0}}};
            quo   <= '0;
            cnt   <= DivLast;
            state <= StDiv;
          end else begin
            cnt <= cnt - 4'd1;
          end
        end
        StDiv: begin
          rem <= fits ? (rem - dsh) : rem;
          dsh <= {1'b0, dsh[NumW-1:1]};
          quo <= {quo[AngleW-2:0], fits};
          cnt <= cnt - 4'd1;
          if (cnt == '0) begin
            state <= StDone;
          end
        end
        StDone: begin
          // hold until the output register can take the word
          if (slot_free) begin
            current_angle <= pos_next;
            moving_flag   <= elapsed_ticks != ramp_ms;
            out_position  <= pos_next;
            out_drive     <= pos_next != current_angle;
            out_motion    <= elapsed_ticks != ramp_ms;
            out_hold      <= 1'b0;
            state         <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/servo_angle_ramp_tb.sv =====
// ---------------------------------------------------------------------------
// servo_angle_ramp_tb: self-checking bench for the servo angle ramp generator
// A directed table covers reset values, clamping, ignored commands and
// pause/resume/retarget corners. Random move/tick sequences follow under
// several ramp settings, including a ramp cut short mid-move. Every result
// word is compared with an in-bench model of the angle interpolation or a typed-in want.
// ---------------------------------------------------------------------------
`default_nettype none

module servo_angle_ramp_tb;
  import sar_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FuncW-1:0]   FuncSpare5 = 3'd5;
  localparam logic [FuncW-1:0]   FuncSpare6 = 3'd6;
  localparam logic [FuncW-1:0]   FuncSpare7 = 3'd7;
  localparam logic [CfgIdxW-1:0] RegSpare2  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3  = 2'd3;
  localparam int StallLimit  = 2000;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic [AngleW-1:0] position;
    logic              drive_write;
    logic              in_motion;
    logic              on_hold;
  } servo_word_t;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [AngleW-1:0] angle;
    logic              has_want;
    servo_word_t       want;
  } command_row_t;

  // wants are typed in only where they follow at a glance from the rows before
  localparam command_row_t DirectedRows [25] = '{
    '{FuncTick,   8'd0,   1'b1, '{8'd90,  1'b0, 1'b0, 1'b0}},
    '{FuncPause,  8'd0,   1'b1, '{8'd90,  1'b0, 1'b0, 1'b0}},
    '{FuncResume, 8'd0,   1'b1, '{8'd90,  1'b0, 1'b0, 1'b0}},
    '{FuncMove,   8'd90,  1'b1, '{8'd90,  1'b0, 1'b0, 1'b0}},
    '{FuncSpare5, 8'hFF,  1'b1, '{8'd90,  1'b0, 1'b0, 1'b0}},
    '{FuncSpare7, 8'hAA,  1'b1, '{8'd90,  1'b0, 1'b0, 1'b0}},
    '{FuncJump,   8'd255, 1'b1, '{8'd180, 1'b1, 1'b0, 1'b0}},
    '{FuncJump,   8'd0,   1'b1, '{8'd0,   1'b1, 1'b0, 1'b0}},
    '{FuncJump,   8'd181, 1'b1, '{8'd180, 1'b1, 1'b0, 1'b0}},
    '{FuncJump,   8'd180, 1'b1, '{8'd180, 1'b1, 1'b0, 1'b0}},
    '{FuncMove,   8'd0,   1'b1, '{8'd180, 1'b0, 1'b1, 1'b0}},
    '{FuncTick,   8'd0,   1'b0, '0},
    '{FuncTick,   8'd0,   1'b0, '0},
    '{FuncPause,  8'd0,   1'b0, '0},
    '{FuncTick,   8'd0,   1'b0, '0},
    '{FuncPause,  8'd0,   1'b0, '0},
    '{FuncResume, 8'd0,   1'b0, '0},
    '{FuncMove,   8'd0,   1'b0, '0},
    '{FuncPause,  8'd0,   1'b0, '0},
    '{FuncMove,   8'd200, 1'b0, '0},
    '{FuncTick,   8'd0,   1'b0, '0},
    '{FuncSpare6, 8'h55,  1'b0, '0},
    '{FuncJump,   8'd128, 1'b1, '{8'd128, 1'b1, 1'b0, 1'b0}},
    '{FuncMove,   8'd55,  1'b0, '0},
    '{FuncTick,   8'd0,   1'b0, '0}
  };

  logic clk;
  logic rst;

  sar_cmd_if cmd_ch ();
  sar_res_if res_ch ();
  sar_cfg_if cfg_ch ();

  servo_angle_ramp u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // servo state as the bench sees it
  logic [AngleW-1:0] ang_now, ang_from, ang_to, rest_deg;
  logic [RampW-1:0]  ticks_done, ramp_len;
  logic              moving, paused;

  command_row_t queued_commands [$];
  servo_word_t  predicted_words [$];
  command_row_t cmd_in_flight;
  servo_word_t  cmd_word;
  bit           cmd_active;
  bit           cmd_taken, res_taken, calm;
  int           gap_left, stall_left, idle_cycles;
  int           n_errors, n_commands, n_active, n_results, n_writes;
  int           n_moves, n_arrivals;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [AngleW-1:0] clamp_deg(input logic [CfgDataW-1:0] a);
    return (a > AngleMax) ? AngleMax : a[AngleW-1:0];
  endfunction

  // round-half-up linear interpolation between ang_from and ang_to
  function automatic logic [AngleW-1:0] ramp_angle();
    longint r, s, d, e, num, q;
    r = ramp_len;
    s = ang_from;
    d = longint'(ang_to) - s;
    e = ticks_done;
    num = 2 * s * r + 2 * d * e + r;
    if (num < 0) num = 0;
    q = num / (2 * r);
    if (q > AngleMax) q = AngleMax;
    return q[AngleW-1:0];
  endfunction

  function automatic void advance_servo(input logic [FuncW-1:0] f,
                                        input logic [AngleW-1:0] a,
                                        output servo_word_t w, output bit active);
    logic [AngleW-1:0] req, nxt, was_now, was_to;
    logic [RampW-1:0]  was_ticks;
    logic              drive, was_mov, was_pau;
    req = clamp_deg(CfgDataW'(a));
    drive = 1'b0;
    was_now = ang_now;
    was_to = ang_to;
    was_ticks = ticks_done;
    was_mov = moving;
    was_pau = paused;
    case (f)
      FuncTick: begin
        if (moving) begin
          ticks_done = ticks_done + 1'b1;
          if (ticks_done > ramp_len) ticks_done = ramp_len;
          nxt = ramp_angle();
          if (nxt != ang_now) begin
            ang_now = nxt;
            drive = 1'b1;
          end
          if (ticks_done >= ramp_len) begin
            moving = 1'b0;
            n_arrivals++;
          end
        end
      end
      FuncJump: begin
        ang_now = req;
        ang_from = req;
        ang_to = req;
        moving = 1'b0;
        paused = 1'b0;
        drive = 1'b1;
      end
      FuncMove: begin
        if (!(req == ang_to && !moving && !paused)) begin
          ang_from = ang_now;
          ang_to = req;
          ticks_done = '0;
          moving = 1'b1;
          paused = 1'b0;
          n_moves++;
        end
      end
      FuncPause: begin
        if (moving && !paused) begin
          moving = 1'b0;
          paused = 1'b1;
        end
      end
      FuncResume: begin
        if (paused) begin
          moving = 1'b1;
          paused = 1'b0;
        end
      end
      default: ;
    endcase
    w = '{ang_now, drive, moving, paused};
    active = drive || (was_now != ang_now) || (was_to != ang_to) ||
             (was_ticks != ticks_done) || (was_mov != moving) || (was_pau != paused);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("  mismatch on %s at result %0d: got %0d, want %0d",
             field, n_results, got, want);
    n_errors++;
  endtask

  // command driver: one word in flight, gap drawn per word
  initial begin
    forever begin
      @(negedge clk);
      if (rst) begin
        cmd_ch.valid <= 1'b0;
      end else if (!cmd_ch.valid || cmd_taken) begin
        cmd_taken = 1'b0;
        if (gap_left > 0) begin
          cmd_ch.valid <= 1'b0;
          gap_left--;
        end else if (queued_commands.size() > 0) begin
          cmd_in_flight = queued_commands.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.func  <= cmd_in_flight.func;
          cmd_ch.angle <= cmd_in_flight.angle;
          gap_left = calm ? 0 : $urandom_range(0, 4);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // predict at acceptance
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
      advance_servo(cmd_ch.func, cmd_ch.angle, cmd_word, cmd_active);
      if (cmd_in_flight.has_want) cmd_word = cmd_in_flight.want;
      predicted_words.push_back(cmd_word);
      cmd_taken = 1'b1;
      n_commands++;
      if (cmd_active) n_active++;
    end
  end

  // result receiver: stall drawn per word
  initial begin
    forever begin
      @(negedge clk);
      if (res_taken) begin
        res_taken = 1'b0;
        stall_left = calm ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      res_taken = 1'b1;
      n_results++;
      if (predicted_words.size() == 0) begin
        report_mismatch("unexpected word, position", res_ch.position, -1);
      end else begin
        servo_word_t w;
        w = predicted_words.pop_front();
        if (res_ch.position !== w.position)
          report_mismatch("position", res_ch.position, w.position);
        if (res_ch.drive_write !== w.drive_write)
          report_mismatch("drive_write", res_ch.drive_write, w.drive_write);
        if (res_ch.in_motion !== w.in_motion)
          report_mismatch("in_motion", res_ch.in_motion, w.in_motion);
        if (res_ch.on_hold !== w.on_hold)
          report_mismatch("on_hold", res_ch.on_hold, w.on_hold);
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("timeout: no handshake for %0d cycles", StallLimit);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_command(input logic [FuncW-1:0] f, input logic [AngleW-1:0] a);
    // hold the producer close to the driver so budgets track accepted words
    while (queued_commands.size() > 1) @(posedge clk);
    queued_commands.push_back('{f, a, 1'b0, '0});
  endtask

  task automatic drain_all();
    while (queued_commands.size() > 0 || cmd_ch.valid || predicted_words.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    drain_all();
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      RegRampMs: begin
        if (data < RampMin) ramp_len = RampMin;
        else if (data > RampMax) ramp_len = RampMax;
        else ramp_len = data[RampW-1:0];
      end
      RegRestAngle: rest_deg = clamp_deg(data);
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [AngleW-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return AngleMax;
      2:       return AngleW'($urandom_range(181, 255));
      default: return AngleW'($urandom_range(0, 180));
    endcase
  endfunction

  // mostly move-then-tick runs with pauses and retargets, plus jumps and noise
  task automatic run_traffic(input int budget);
    int goal, n, k;
    goal = n_active + budget;
    while (n_active < goal) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          queue_command(FuncMove, pick_angle());
          n = $urandom_range(1, 260);
          for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 2) begin
              queue_command(FuncPause, AngleW'($urandom_range(0, 255)));
              repeat ($urandom_range(0, 3)) queue_command(FuncTick, 8'd0);
              if ($urandom_range(0, 3) != 0)
                queue_command(FuncResume, AngleW'($urandom_range(0, 255)));
            end else if (k < 3) begin
              queue_command(FuncMove, pick_angle());
            end else begin
              queue_command(FuncTick, AngleW'($urandom_range(0, 255)));
            end
          end
        end
        11, 12, 13: queue_command(FuncJump, pick_angle());
        14: drain_all();
        15: calm = !calm;
        default: queue_command(FuncW'($urandom_range(0, 7)), AngleW'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.func  = FuncTick;
    cmd_ch.angle = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegRampMs;
    cfg_ch.data  = '0;
    res_ch.ready = 1'b0;
    ramp_len   = RampReset;
    rest_deg   = RestAngle;
    ang_now    = RestAngle;
    ang_from   = RestAngle;
    ang_to     = RestAngle;
    ticks_done = '0;
    moving     = 1'b0;
    paused     = 1'b0;
    calm       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DirectedRows[i]) begin
      while (queued_commands.size() > 1) @(posedge clk);
      queued_commands.push_back(DirectedRows[i]);
    end

    // shortest ramp; rest angle write must not change behavior
    write_register(RegRestAngle, 16'd255);
    write_register(RegRampMs, 16'd0);
    run_traffic(450);

    write_register(RegSpare2, 16'hFFFF);
    write_register(RegSpare3, 16'h1234);
    write_register(RegRampMs, 16'd357);
    run_traffic(300);

    // long ramp, then cut it below the elapsed count mid-move
    write_register(RegRampMs, 16'hFFFF);
    queue_command(FuncJump, 8'd0);
    queue_command(FuncMove, AngleMax);
    repeat (250) queue_command(FuncTick, 8'd0);
    write_register(RegRampMs, 16'd200);
    queue_command(FuncTick, 8'd0);
    queue_command(FuncTick, 8'd0);
    run_traffic(200);

    write_register(RegRampMs, 16'd10000);
    write_register(RegRestAngle, 16'd0);
    run_traffic(80);

    drain_all();
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d commands (%0d state-changing), %0d moves, %0d arrivals",
             n_commands, n_active, n_moves, n_arrivals);
    $display("checked %0d result words across %0d register writes, %0d mismatches",
             n_results, n_writes, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/sar_pkg.sv
src/sar_ifs.sv
src/servo_angle_ramp.sv
tb/servo_angle_ramp_tb.sv
